/* design/buddy_page_allocator_top_macros.svh */
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is high.
`define BPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define BPA_ASSERT(label, prop, msg)
`define BPA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* design/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Types, codes, bitmap layout and small helper functions.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int PAGES      = 1024;
   localparam int PAGE_W     = 10;
   localparam int RANK_W     = 5;
   localparam int RANK_LIMIT = 16;
   localparam int COUNT_W    = 11;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = 5;
   localparam int BM_DEPTH   = 68;
   localparam int BM_AW      = 7;
   localparam int MAX_TOP    = 11;

   // Classified operation codes passed from front to back.
   localparam logic [2:0] OP_INIT   = 3'd0;
   localparam logic [2:0] OP_ALLOC  = 3'd1;
   localparam logic [2:0] OP_FREE   = 3'd2;
   localparam logic [2:0] OP_QRANK  = 3'd3;
   localparam logic [2:0] OP_QCOUNT = 3'd4;
   localparam logic [2:0] OP_REJECT = 3'd5;

   // Command codes on the request port.
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_ALLOC  = 3'd1;
   localparam logic [2:0] CMD_FREE   = 3'd2;
   localparam logic [2:0] CMD_QRANK  = 3'd3;
   localparam logic [2:0] CMD_QCOUNT = 3'd4;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVAL   = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;

   typedef struct packed {
      logic [2:0]        op;
      logic [RANK_W-1:0] rank;
      logic [PAGE_W-1:0] page;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [PAGE_W-1:0]  start_page;
      logic [COUNT_W-1:0] value;
   } rsp_type;

   // First bitmap word of each rank.
   function automatic logic [BM_AW-1:0] rank_base(input logic [RANK_W-1:0] r);
      logic [BM_AW-1:0] b;
      case (r)
         5'd1:    b = 7'd0;
         5'd2:    b = 7'd32;
         5'd3:    b = 7'd48;
         5'd4:    b = 7'd56;
         5'd5:    b = 7'd60;
         5'd6:    b = 7'd62;
         5'd7:    b = 7'd63;
         5'd8:    b = 7'd64;
         5'd9:    b = 7'd65;
         5'd10:   b = 7'd66;
         5'd11:   b = 7'd67;
         default: b = 7'd0;
      endcase
      return b;
   endfunction

   // Number of bitmap words of each rank; ranks with no blocks have none.
   function automatic logic [5:0] rank_words(input logic [RANK_W-1:0] r);
      logic [5:0] n;
      case (r)
         5'd1:    n = 6'd32;
         5'd2:    n = 6'd16;
         5'd3:    n = 6'd8;
         5'd4:    n = 6'd4;
         5'd5:    n = 6'd2;
         5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11: n = 6'd1;
         default: n = 6'd0;
      endcase
      return n;
   endfunction

   // Word address holding block index idx of rank r.
   function automatic logic [BM_AW-1:0] bm_addr(input logic [RANK_W-1:0] r,
                                                 input logic [PAGE_W-1:0] idx);
      return rank_base(r) + BM_AW'(idx[PAGE_W-1:BIT_W]);
   endfunction

   // Position of the lowest set bit.
   function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] b;
      b = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            b = BIT_W'(i);
         end
      end
      return b;
   endfunction

   // Number of set bits.
   function automatic logic [BIT_W:0] pop_count(input logic [WORD_W-1:0] w);
      logic [BIT_W:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + (BIT_W + 1)'(w[i]);
      end
      return n;
   endfunction

   // Rank of the largest power-of-two region within c pages.
   function automatic logic [RANK_W-1:0] top_of(input logic [COUNT_W-1:0] c);
      logic [RANK_W-1:0] r;
      r = 5'd1;
      for (int i = 0; i < COUNT_W; i++) begin
         if (c[i]) begin
            r = RANK_W'(i + 1);
         end
      end
      return r;
   endfunction

endpackage

/* design/bpa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator front end
// Accepts request words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module bpa_front import bpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_command,
   input  logic [RANK_W-1:0] req_rank,
   input  logic [PAGE_W-1:0] req_page,
   output logic              cmd_valid,
   output cmd_type           cmd_data,
   input  logic              cmd_pop
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       rank_ok;
   cmd_type    cls;

   // Classify the command; argument errors that need no state are settled here.
   always_comb begin
      rank_ok  = (req_rank >= 5'd1) && (req_rank <= RANK_W'(RANK_LIMIT));
      cls.rank = req_rank;
      cls.page = req_page;
      case (req_command)
         CMD_INIT:   cls.op = OP_INIT;
         CMD_ALLOC:  cls.op = rank_ok ? OP_ALLOC : OP_REJECT;
         CMD_FREE:   cls.op = OP_FREE;
         CMD_QRANK:  cls.op = OP_QRANK;
         CMD_QCOUNT: cls.op = rank_ok ? OP_QCOUNT : OP_REJECT;
         default:    cls.op = OP_REJECT;
      endcase
   end

   // Queue pointers and fill count.
   assign req_full  = (cnt_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* design/bpa_rsp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator result queue
// Two-entry queue that parts the back end from the result port.
// ----------------------------------------------------------------------------
module bpa_rsp_fifo import bpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_type            push_data,
   output logic               full,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic [PAGE_W-1:0]  rsp_start_page,
   output logic [COUNT_W-1:0] rsp_value
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr;
   logic       rd;
   rsp_type    head;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign wr        = push && !full;
   assign rd        = rsp_pop && !rsp_empty;

   // Head word onto the ports.
   assign head           = entry_ff[rd_ptr_ff];
   assign rsp_status     = head.status;
   assign rsp_start_page = head.start_page;
   assign rsp_value      = head.value;

   always_comb begin
      wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(wr) - 2'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/bpa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator back end
// Sequencer over the free bitmap and owner memories that carries out commands.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_top_macros.svh"
module bpa_back import bpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] page_count,
   input  logic               cmd_valid,
   input  cmd_type            cmd_data,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rsp_type            rsp_data
);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_CLEAR      = 5'd1;
   localparam logic [4:0] S_SETTOP     = 5'd2;
   localparam logic [4:0] S_A_RD       = 5'd3;
   localparam logic [4:0] S_A_CHK      = 5'd4;
   localparam logic [4:0] S_A_SPLIT_RD = 5'd5;
   localparam logic [4:0] S_A_SPLIT_WR = 5'd6;
   localparam logic [4:0] S_A_OWN      = 5'd7;
   localparam logic [4:0] S_F_OWN      = 5'd8;
   localparam logic [4:0] S_F_RD       = 5'd9;
   localparam logic [4:0] S_F_MRG      = 5'd10;
   localparam logic [4:0] S_Q_OWN      = 5'd11;
   localparam logic [4:0] S_Q_RD       = 5'd12;
   localparam logic [4:0] S_Q_CHK      = 5'd13;
   localparam logic [4:0] S_C_RD       = 5'd14;
   localparam logic [4:0] S_C_ADD      = 5'd15;
   localparam logic [4:0] S_DONE       = 5'd16;

   // Memories.
   logic [WORD_W-1:0] bm_mem    [BM_DEPTH];
   logic [RANK_W-1:0] owner_mem [PAGES];

   logic [WORD_W-1:0] bm_rdata_ff;
   logic [RANK_W-1:0] owner_rdata_ff;
   logic [BM_AW-1:0]  bm_raddr;
   logic              bm_we;
   logic [BM_AW-1:0]  bm_waddr;
   logic [WORD_W-1:0] bm_wdata;
   logic [PAGE_W-1:0] owner_raddr;
   logic              owner_we;
   logic [PAGE_W-1:0] owner_waddr;
   logic [RANK_W-1:0] owner_wdata;

   // Control state.
   logic [4:0]         state_ff, state_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [RANK_W-1:0]  r_ff, r_in;
   logic [PAGE_W-1:0]  pos_ff, pos_in;
   logic [BIT_W-1:0]   widx_ff, widx_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic [PAGE_W-1:0]  clr_ff, clr_in;
   logic [BM_AW-1:0]   bm_addr_ff, bm_addr_in;
   logic               reply_ff, reply_in;
   logic [COUNT_W-1:0] live_ff, live_in;
   logic [RANK_W-1:0]  top_ff, top_in;
   rsp_type            res_ff, res_in;

   logic [PAGE_W-1:0]  blk_idx;
   logic [PAGE_W-1:0]  split_idx;
   logic [PAGE_W-1:0]  scan_idx;
   logic [BIT_W-1:0]   lb;
   logic [5:0]         next_widx;
   logic [COUNT_W-1:0] eff;
   logic [WORD_W-1:0]  merged;
   logic [BIT_W-1:0]   bud_bit;

   // Block index arithmetic for the current rank and page.
   always_comb begin
      blk_idx   = pos_ff >> (r_ff - 5'd1);
      split_idx = blk_idx + 10'd1;
      lb        = low_bit(bm_rdata_ff);
      scan_idx  = {widx_ff, lb};
      next_widx = {1'b0, widx_ff} + 6'd1;
      bud_bit   = blk_idx[BIT_W-1:0] ^ 5'd1;
      merged    = bm_rdata_ff | (WORD_W'(1) << blk_idx[BIT_W-1:0]);
      if (page_count == 11'd0) begin
         eff = 11'd1;
      end else if (page_count > COUNT_W'(PAGES)) begin
         eff = COUNT_W'(PAGES);
      end else begin
         eff = page_count;
      end
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      rank_in     = rank_ff;
      r_in        = r_ff;
      pos_in      = pos_ff;
      widx_in     = widx_ff;
      acc_in      = acc_ff;
      clr_in      = clr_ff;
      bm_addr_in  = bm_addr_ff;
      reply_in    = reply_ff;
      live_in     = live_ff;
      top_in      = top_ff;
      res_in      = res_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      bm_raddr    = bm_addr_ff;
      bm_we       = 1'b0;
      bm_waddr    = bm_addr_ff;
      bm_wdata    = bm_rdata_ff;
      owner_raddr = cmd_data.page;
      owner_we    = 1'b0;
      owner_waddr = pos_ff;
      owner_wdata = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               rank_in = cmd_data.rank;
               pos_in  = cmd_data.page;
               res_in  = '0;
               widx_in = '0;
               acc_in  = '0;
               case (cmd_data.op)
                  OP_INIT: begin
                     live_in  = eff;
                     top_in   = top_of(eff);
                     clr_in   = '0;
                     reply_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  OP_ALLOC: begin
                     if (cmd_data.rank > top_ff) begin
                        res_in.status = ST_NOSPACE;
                        state_in      = S_DONE;
                     end else begin
                        r_in     = cmd_data.rank;
                        state_in = S_A_RD;
                     end
                  end
                  OP_FREE: begin
                     if ({1'b0, cmd_data.page} >= live_ff) begin
                        res_in.status = ST_INVAL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_F_OWN;
                     end
                  end
                  OP_QRANK: begin
                     if ({1'b0, cmd_data.page} >= live_ff) begin
                        res_in.status = ST_INVAL;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_Q_OWN;
                     end
                  end
                  OP_QCOUNT: begin
                     if (rank_words(cmd_data.rank) == 6'd0) begin
                        state_in = S_DONE;
                     end else begin
                        r_in     = cmd_data.rank;
                        state_in = S_C_RD;
                     end
                  end
                  default: begin
                     res_in.status = ST_INVAL;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         // Sweep both memories back to zero.
         S_CLEAR: begin
            owner_we    = 1'b1;
            owner_waddr = clr_ff;
            bm_we       = (clr_ff < PAGE_W'(BM_DEPTH));
            bm_waddr    = clr_ff[BM_AW-1:0];
            bm_wdata    = '0;
            clr_in      = clr_ff + 10'd1;
            if (clr_ff == PAGE_W'(PAGES - 1)) begin
               state_in = S_SETTOP;
            end
         end
         // Free the whole region.
         S_SETTOP: begin
            bm_we    = 1'b1;
            bm_waddr = rank_base(top_ff);
            bm_wdata = WORD_W'(1);
            state_in = reply_ff ? S_DONE : S_IDLE;
         end
         // Scan the bitmap words of rank r for a free block.
         S_A_RD: begin
            bm_raddr   = rank_base(r_ff) + BM_AW'(widx_ff);
            bm_addr_in = bm_raddr;
            state_in   = S_A_CHK;
         end
         S_A_CHK: begin
            if (bm_rdata_ff != '0) begin
               bm_we    = 1'b1;
               bm_wdata = bm_rdata_ff & ~(WORD_W'(1) << lb);
               pos_in   = PAGE_W'(scan_idx << (r_ff - 5'd1));
               if (r_ff > rank_ff) begin
                  r_in     = r_ff - 5'd1;
                  state_in = S_A_SPLIT_RD;
               end else begin
                  state_in = S_A_OWN;
               end
            end else if (next_widx < rank_words(r_ff)) begin
               widx_in  = next_widx[BIT_W-1:0];
               state_in = S_A_RD;
            end else if (r_ff >= top_ff) begin
               res_in.status = ST_NOSPACE;
               state_in      = S_DONE;
            end else begin
               r_in     = r_ff + 5'd1;
               widx_in  = '0;
               state_in = S_A_RD;
            end
         end
         // Free the upper half at each lower rank.
         S_A_SPLIT_RD: begin
            bm_raddr   = bm_addr(r_ff, split_idx);
            bm_addr_in = bm_raddr;
            state_in   = S_A_SPLIT_WR;
         end
         S_A_SPLIT_WR: begin
            bm_we    = 1'b1;
            bm_wdata = bm_rdata_ff | (WORD_W'(1) << split_idx[BIT_W-1:0]);
            if (r_ff > rank_ff) begin
               r_in     = r_ff - 5'd1;
               state_in = S_A_SPLIT_RD;
            end else begin
               state_in = S_A_OWN;
            end
         end
         S_A_OWN: begin
            owner_we          = 1'b1;
            owner_wdata       = rank_ff;
            res_in.start_page = pos_ff;
            state_in          = S_DONE;
         end
         // Free: check the owner entry, then merge upwards.
         S_F_OWN: begin
            if (owner_rdata_ff == '0) begin
               res_in.status = ST_INVAL;
               state_in      = S_DONE;
            end else begin
               owner_we = 1'b1;
               r_in     = owner_rdata_ff;
               state_in = S_F_RD;
            end
         end
         S_F_RD: begin
            bm_raddr   = bm_addr(r_ff, blk_idx);
            bm_addr_in = bm_raddr;
            state_in   = S_F_MRG;
         end
         S_F_MRG: begin
            bm_we = 1'b1;
            if ((r_ff < top_ff) && merged[bud_bit]) begin
               bm_wdata = merged & ~(WORD_W'(1) << blk_idx[BIT_W-1:0])
                                 & ~(WORD_W'(1) << bud_bit);
               pos_in   = pos_ff & ~(PAGE_W'(1) << (r_ff - 5'd1));
               r_in     = r_ff + 5'd1;
               state_in = S_F_RD;
            end else begin
               bm_wdata = merged;
               state_in = S_DONE;
            end
         end
         // Query rank: owner first, then free bitmaps from the top down.
         S_Q_OWN: begin
            if (owner_rdata_ff != '0) begin
               res_in.value = COUNT_W'(owner_rdata_ff);
               state_in     = S_DONE;
            end else begin
               r_in     = top_ff;
               state_in = S_Q_RD;
            end
         end
         S_Q_RD: begin
            bm_raddr   = bm_addr(r_ff, blk_idx);
            bm_addr_in = bm_raddr;
            state_in   = S_Q_CHK;
         end
         S_Q_CHK: begin
            if (bm_rdata_ff[blk_idx[BIT_W-1:0]]) begin
               res_in.value = COUNT_W'(r_ff);
               state_in     = S_DONE;
            end else if (r_ff == 5'd1) begin
               res_in.status = ST_INVAL;
               state_in      = S_DONE;
            end else begin
               r_in     = r_ff - 5'd1;
               state_in = S_Q_RD;
            end
         end
         // Count free blocks one word at a time.
         S_C_RD: begin
            bm_raddr = rank_base(r_ff) + BM_AW'(widx_ff);
            state_in = S_C_ADD;
         end
         S_C_ADD: begin
            acc_in = acc_ff + COUNT_W'(pop_count(bm_rdata_ff));
            if (next_widx < rank_words(r_ff)) begin
               widx_in  = next_widx[BIT_W-1:0];
               state_in = S_C_RD;
            end else begin
               res_in.value = acc_in;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            rsp_push = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_data = res_ff;

   // Control registers; reset runs the clearing pass over a full region.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         reply_ff <= 1'b0;
         live_ff  <= COUNT_W'(PAGES);
         top_ff   <= RANK_W'(MAX_TOP);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         reply_ff <= reply_in;
         live_ff  <= live_in;
         top_ff   <= top_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rank_ff    <= rank_in;
      r_ff       <= r_in;
      pos_ff     <= pos_in;
      widx_ff    <= widx_in;
      acc_ff     <= acc_in;
      bm_addr_ff <= bm_addr_in;
      res_ff     <= res_in;
   end

   // Free bitmap memory.
   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_waddr] <= bm_wdata;
      end
      bm_rdata_ff <= bm_mem[bm_raddr];
   end

   // Owner rank memory.
   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[owner_waddr] <= owner_wdata;
      end
      owner_rdata_ff <= owner_mem[owner_raddr];
   end

   // A word is taken only when the result queue has room for its answer.
   `BPA_ASSERT(a_pop_room, cmd_pop |-> !rsp_full, "command taken with result queue full")
   // Bitmap walks never run at rank zero.
   `BPA_ASSERT(a_rank_nonzero, (state_ff == S_F_RD || state_ff == S_Q_RD ||
      state_ff == S_A_RD || state_ff == S_A_SPLIT_RD) |-> (r_ff != 5'd0),
      "bitmap access at rank zero")
   // The region rank stays within the bitmap layout.
   `BPA_ASSERT(a_top_range, (top_ff >= 5'd1) && (top_ff <= RANK_W'(MAX_TOP)),
      "region rank out of range")
   // A result push is always followed by a return to idle.
   `BPA_ASSERT(a_push_done, rsp_push |=> (state_ff == S_IDLE),
      "result push not followed by idle")

endmodule

/* design/buddy_page_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator
// Buddy allocator over 1024 pages with ranks 1 to 16, one result per command.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Direction
//  request   req_push/req_full, command, rank, page        in
//  result    rsp_empty/rsp_pop, status, start_page, value  out
//  csr       csr_wr_en, csr_wr_data (page count)           in
//
// Command time is set by the back-end sequencer and its bitmap memory: alloc
// reads and checks each bitmap word scanned and reads and writes each split,
// free reads and merges each level, query_rank reads the owner entry, then
// the bitmaps from the top rank down, query_count reads and adds each word.
// Init clears both memories and then frees the region; reset runs the same
// pass and the back end starts no word until it ends.
// Two queued request words and two results decouple stalls on either side.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top import bpa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_command,
   input  logic [RANK_W-1:0]  req_rank,
   input  logic [PAGE_W-1:0]  req_page,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic [PAGE_W-1:0]  rsp_start_page,
   output logic [COUNT_W-1:0] rsp_value,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   logic [COUNT_W-1:0] page_count_ff;
   logic               cmd_valid;
   cmd_type            cmd_data;
   logic               cmd_pop;
   logic               rsp_full;
   logic               rsp_push;
   rsp_type            rsp_data;

   // Page count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= COUNT_W'(PAGES);
      end else if (csr_wr_en) begin
         page_count_ff <= csr_wr_data;
      end
   end

   bpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_command (req_command),
      .req_rank    (req_rank),
      .req_page    (req_page),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop)
   );

   bpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .page_count (page_count_ff),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data),
      .cmd_pop    (cmd_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data)
   );

   bpa_rsp_fifo u_rsp (
      .clock          (clock),
      .reset          (reset),
      .push           (rsp_push),
      .push_data      (rsp_data),
      .full           (rsp_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_start_page (rsp_start_page),
      .rsp_value      (rsp_value)
   );

endmodule

/* bench/buddy_page_allocator_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives commands through the request queue, predicts every result word with
// an independent model of the bitmaps and owner table, and checks each popped
// word against the oldest prediction, under several idling and stall mixes.
// ----------------------------------------------------------------------------
module buddy_page_allocator_top_test;
   import bpa_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   // Command codes that the block does not know.
   localparam logic [2:0] CMD_BAD_LOW  = 3'd5;
   localparam logic [2:0] CMD_BAD_HIGH = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [2:0]         req_command;
   logic [RANK_W-1:0]  req_rank;
   logic [PAGE_W-1:0]  req_page;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [1:0]         rsp_status;
   logic [PAGE_W-1:0]  rsp_start_page;
   logic [COUNT_W-1:0] rsp_value;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   // Allocator model state.
   logic [PAGES-1:0]   free_map [1:RANK_LIMIT];
   logic [RANK_W-1:0]  alloc_rank [PAGES];
   int                 top_rank;
   int                 page_count;
   int                 live_pages;
   int                 held_blocks[$];

   rsp_type            pending_words[$];
   int                 error_count;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 pop_stall_pct;
   int                 pop_hold;

   buddy_page_allocator_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_rank       (req_rank),
      .req_page       (req_page),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_start_page (rsp_start_page),
      .rsp_value      (rsp_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("buddy_page_allocator_top_test: FAIL");
         $finish;
      end
   end

   // Clears the allocator and frees the largest power-of-two region.
   function automatic void model_init();
      int pow;
      pow = 1;
      for (int r = 1; r <= RANK_LIMIT; r++) begin
         free_map[r] = '0;
      end
      for (int p = 0; p < PAGES; p++) begin
         alloc_rank[p] = '0;
      end
      live_pages = page_count < 1 ? 1 : (page_count > PAGES ? PAGES : page_count);
      while (pow * 2 <= live_pages) begin
         pow = pow * 2;
      end
      top_rank = 1;
      while (top_rank < RANK_LIMIT && (1 << top_rank) <= pow) begin
         top_rank++;
      end
      free_map[top_rank][0] = 1'b1;
   endfunction

   // First page of the lowest free block of rank r, or -1.
   function automatic int lowest_block(int r);
      int n;
      n = PAGES >> (r - 1);
      for (int i = 0; i < n; i++) begin
         if (free_map[r][i]) begin
            return i << (r - 1);
         end
      end
      return -1;
   endfunction

   // Applies one command to the model and returns the word it must produce.
   function automatic rsp_type model_command(logic [2:0] cmd, int rank, int page);
      rsp_type w;
      int      r;
      int      pos;
      int      buddy;
      w = '0;
      case (cmd)
         CMD_INIT: begin
            model_init();
         end
         CMD_ALLOC: begin
            pos = -1;
            if (rank < 1 || rank > RANK_LIMIT) begin
               w.status = ST_INVAL;
            end else if (rank > top_rank) begin
               w.status = ST_NOSPACE;
            end else begin
               for (r = rank; r <= top_rank; r++) begin
                  pos = lowest_block(r);
                  if (pos >= 0) break;
               end
               if (pos < 0) begin
                  w.status = ST_NOSPACE;
               end else begin
                  free_map[r][pos >> (r - 1)] = 1'b0;
                  while (r > rank) begin
                     r--;
                     free_map[r][(pos + (1 << (r - 1))) >> (r - 1)] = 1'b1;
                  end
                  alloc_rank[pos] = RANK_W'(rank);
                  w.start_page = PAGE_W'(pos);
                  held_blocks.push_back(pos);
               end
            end
         end
         CMD_FREE: begin
            if (page >= live_pages || alloc_rank[page] == 0) begin
               w.status = ST_INVAL;
            end else begin
               pos = page;
               r = alloc_rank[page];
               alloc_rank[page] = '0;
               foreach (held_blocks[i]) begin
                  if (held_blocks[i] == page) begin
                     held_blocks.delete(i);
                     break;
                  end
               end
               free_map[r][pos >> (r - 1)] = 1'b1;
               // Merge upwards while the buddy is free too.
               while (r < top_rank) begin
                  buddy = pos ^ (1 << (r - 1));
                  if (buddy >= PAGES || !free_map[r][buddy >> (r - 1)]) break;
                  free_map[r][pos >> (r - 1)] = 1'b0;
                  free_map[r][buddy >> (r - 1)] = 1'b0;
                  if (buddy < pos) pos = buddy;
                  r++;
                  free_map[r][pos >> (r - 1)] = 1'b1;
               end
            end
         end
         CMD_QRANK: begin
            if (page >= live_pages) begin
               w.status = ST_INVAL;
            end else if (alloc_rank[page] != 0) begin
               w.value = COUNT_W'(alloc_rank[page]);
            end else begin
               w.status = ST_INVAL;
               for (r = top_rank; r >= 1; r--) begin
                  if (free_map[r][page >> (r - 1)]) begin
                     w.status = ST_OK;
                     w.value = COUNT_W'(r);
                     break;
                  end
               end
            end
         end
         CMD_QCOUNT: begin
            if (rank < 1 || rank > RANK_LIMIT) begin
               w.status = ST_INVAL;
            end else begin
               for (int i = 0; i < (PAGES >> (rank - 1)); i++) begin
                  w.value = w.value + COUNT_W'(free_map[rank][i]);
               end
            end
         end
         default: begin
            w.status = ST_INVAL;
         end
      endcase
      return w;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Result checking.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_start_page !== want.start_page)
               report_mismatch("start_page", rsp_start_page, want.start_page);
            if (rsp_value !== want.value)
               report_mismatch("value", rsp_value, want.value);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Sends one word, records its prediction on acceptance, then maybe idles.
   task automatic send_word(logic [2:0] cmd, int rank, int page);
      int gap;
      req_push    <= 1'b1;
      req_command <= cmd;
      req_rank    <= RANK_W'(rank);
      req_page    <= PAGE_W'(page);
      do begin
         @(posedge clock);
      end while (req_full);
      pending_words.push_back(model_command(cmd, rank, page));
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Register writes happen only with the block idle; the new count takes
   // effect at the following init word.
   task automatic set_page_count(int count);
      wait_drained();
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= COUNT_W'(count);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      page_count  = count;
      send_word(CMD_INIT, 0, 0);
   endtask

   // One random word, mostly well-formed alloc and free traffic.
   task automatic send_random_word();
      int pick;
      int rank;
      int page;
      pick = $urandom_range(99);
      rank = $urandom_range(1, 4);
      page = $urandom_range(0, PAGES - 1);
      if (pick < 40) begin
         if ($urandom_range(9) < 2) rank = $urandom_range(1, top_rank);
         if ($urandom_range(19) == 0) rank = $urandom_range(0, 31);
         send_word(CMD_ALLOC, rank, page);
      end else if (pick < 70) begin
         if (held_blocks.size() != 0 && $urandom_range(99) < 85)
            page = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
         else if ($urandom_range(1) == 0)
            page = $urandom_range(0, live_pages - 1);
         send_word(CMD_FREE, $urandom_range(0, 31), page);
      end else if (pick < 82) begin
         if ($urandom_range(3) != 0) page = $urandom_range(0, live_pages - 1);
         send_word(CMD_QRANK, $urandom_range(0, 31), page);
      end else if (pick < 92) begin
         rank = $urandom_range(3) != 0 ? $urandom_range(1, 12) : $urandom_range(0, 31);
         send_word(CMD_QCOUNT, rank, page);
      end else if (pick < 95) begin
         send_word(CMD_INIT, $urandom_range(0, 31), page);
      end else begin
         send_word(3'($urandom_range(CMD_BAD_LOW, CMD_BAD_HIGH)),
                   $urandom_range(0, 31), page);
      end
   endtask

   task automatic test_directed();
      send_word(CMD_QCOUNT, 11, 0);
      send_word(CMD_QRANK, 0, 1023);
      send_word(CMD_ALLOC, 0, 0);
      send_word(CMD_ALLOC, 17, 0);
      send_word(CMD_ALLOC, 31, 0);
      send_word(CMD_ALLOC, 12, 0);
      send_word(CMD_ALLOC, 1, 0);
      send_word(CMD_ALLOC, 3, 0);
      send_word(CMD_QRANK, 0, 5);
      send_word(CMD_QRANK, 0, 512);
      send_word(CMD_QCOUNT, 1, 0);
      send_word(CMD_QCOUNT, 16, 0);
      send_word(CMD_QCOUNT, 0, 0);
      send_word(CMD_FREE, 0, 5);
      send_word(CMD_FREE, 0, 0);
      send_word(CMD_FREE, 0, 0);
      send_word(CMD_FREE, 0, 4);
      send_word(CMD_ALLOC, 11, 0);
      send_word(CMD_ALLOC, 1, 0);
      send_word(CMD_FREE, 31, 0);
      send_word(CMD_BAD_LOW, 0, 0);
      send_word(CMD_BAD_HIGH, 31, 1023);
      send_word(CMD_INIT, 0, 0);
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (count) send_random_word();
   endtask

   task automatic test_page_count_limits();
      set_page_count(1);
      test_random(20, 0, 0);
      set_page_count(0);
      test_random(20, 0, 0);
      set_page_count(2047);
      test_random(30, 0, 0);
      set_page_count(3);
      test_random(20, 0, 0);
   endtask

   // Receiver holds off while the sender keeps offering, filling the block.
   task automatic test_backpressure();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      pop_hold = 400;
      repeat (40) send_random_word();
      wait_drained();
      repeat (40) send_random_word();
   endtask

   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_command   = CMD_INIT;
      req_rank      = '0;
      req_page      = '0;
      rsp_pop       = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      pop_hold      = 0;
      page_count    = 1024;
      model_init();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(180, 0, 0);
      set_page_count(600);
      test_random(180, 68, 0);
      set_page_count(1024);
      test_random(180, 0, 68);
      set_page_count($urandom_range(2, 1023));
      test_random(120, 68, 68);
      test_page_count_limits();
      set_page_count(1024);
      test_backpressure();
      test_random(100, 14, 14);

      wait_drained();
      repeat (1200) @(posedge clock);
      if (error_count == 0) begin
         $display("buddy_page_allocator_top_test: PASS");
      end else begin
         $display("buddy_page_allocator_top_test: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/bpa_pkg.sv
design/bpa_front.sv
design/bpa_rsp_fifo.sv
design/bpa_back.sv
design/buddy_page_allocator_top.sv
bench/buddy_page_allocator_top_test.sv
